[design/kwl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_pkg
// Shared types, token codes and the keyword table of the keyword lexer.
// ----------------------------------------------------------------------------
package kwl_pkg;

	localparam int LINE_BITS_DEF   = 20;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int OFFSET_BITS_DEF = 24;

	localparam int LEN_BITS    = 16;
	localparam int KIND_BITS   = 5;
	localparam int CHAR_BITS   = 8;
	localparam int KW_COUNT    = 14;
	localparam int KW_MAX_LEN  = 17;
	localparam int KW_POS_BITS = 5;
	localparam int QUEUE_DEPTH = 4;

	typedef logic [KIND_BITS-1:0] kind_t;
	typedef logic [CHAR_BITS-1:0] char_t;
	typedef logic [LEN_BITS-1:0]  len_t;
	typedef logic [KW_COUNT-1:0]  kw_mask_t;
	typedef logic [1:0]           push_cnt_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_STRING,
		MODE_ENDED
	} mode_t;

	localparam kind_t KIND_IDENT   = 5'd0;
	localparam kind_t KIND_NUMBER  = 5'd1;
	localparam kind_t KIND_STRING  = 5'd2;
	localparam kind_t KIND_UNKNOWN = 5'd3;
	localparam kind_t KIND_END     = 5'd4;
	localparam kind_t KIND_KW0     = 5'd5;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_NL    = 8'h0A;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_CR    = 8'h0D;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_QUOTE = 8'h22;
	localparam char_t CH_DOT   = 8'h2E;
	localparam char_t CH_UNDER = 8'h5F;

	localparam kw_mask_t KW_ALL = '1;

	// right-aligned text, first character in the highest used byte
	localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
		"func", "start", "end", "call",
		"safe.add", "safe.sub", "safe.mul", "safe.div",
		"tuple.pack", "tuple.unpack", "list.append", "list.remove",
		"language.parallel", "language.sync"
	};

	localparam logic [KW_POS_BITS-1:0] KW_LEN [KW_COUNT] = '{
		5'd4, 5'd5, 5'd3, 5'd4, 5'd8, 5'd8, 5'd8, 5'd8,
		5'd10, 5'd12, 5'd11, 5'd11, 5'd17, 5'd13
	};

	function automatic kw_mask_t kw_narrow(input kw_mask_t cand, input len_t pos,
			input char_t c);
		kw_mask_t m;
		int       idx;
		m = cand;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (pos >= len_t'(KW_LEN[i])) begin
				m[i] = 1'b0;
			end else begin
				idx = (int'(KW_LEN[i]) - 1 - int'(pos[KW_POS_BITS-1:0])) * 8;
				if (KW_TEXT[i][idx +: 8] != c)
					m[i] = 1'b0;
			end
		end
		return m;
	endfunction

	function automatic kind_t kw_kind(input kw_mask_t cand, input len_t len);
		kind_t k;
		k = KIND_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			if (cand[i] && len == len_t'(KW_LEN[i]))
				k = KIND_KW0 + kind_t'(i);
		end
		return k;
	endfunction

endpackage

[design/kwl_res_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_res_queue
// Small result queue; takes up to two beats per cycle, hands out one unless the reader stalls.
// ----------------------------------------------------------------------------
module kwl_res_queue #(
	parameter int WIDTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kwl_pkg::push_cnt_t  push_cnt,
	input  logic [WIDTH-1:0]    push_d0,
	input  logic [WIDTH-1:0]    push_d1,
	output logic                room,
	output logic                rd_valid,
	input  logic                rd_stall,
	output logic [WIDTH-1:0]    rd_data
);

	localparam int DEPTH = kwl_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_ptr_nx;
	logic             pop;

	assign rd_valid  = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];
	assign pop       = rd_valid & ~rd_stall;
	assign room      = (count_q <= CNT_W'(DEPTH - 2));
	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + CNT_W'(push_cnt) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push_d0;
		if (push_cnt == 2'd2)
			mem_q[wr_ptr_nx] <= push_d1;
	end

endmodule

[design/kwl_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_scanner
// Token state machine, position counters and keyword candidate mask.
// ----------------------------------------------------------------------------
module kwl_scanner #(
	parameter int LINE_BITS   = kwl_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = kwl_pkg::COLUMN_BITS_DEF,
	parameter int OFFSET_BITS = kwl_pkg::OFFSET_BITS_DEF,
	parameter int RES_W = kwl_pkg::KIND_BITS + LINE_BITS + COLUMN_BITS + OFFSET_BITS
		+ kwl_pkg::LEN_BITS + kwl_pkg::CHAR_BITS + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  kwl_pkg::char_t     c,
	output kwl_pkg::push_cnt_t push_cnt,
	output logic [RES_W-1:0]   res0,
	output logic [RES_W-1:0]   res1
);

	kwl_pkg::mode_t             mode_q, mode_d;
	logic [LINE_BITS-1:0]       line_q, line_d;
	logic [COLUMN_BITS-1:0]     col_q, col_d;
	logic [OFFSET_BITS-1:0]     off_q, off_d;
	logic [COLUMN_BITS-1:0]     beg_col_q, beg_col_d;
	logic [OFFSET_BITS-1:0]     beg_off_q, beg_off_d;
	kwl_pkg::len_t              len_q, len_d;
	kwl_pkg::kw_mask_t          cand_q, cand_d;

	logic is_letter, is_digit, is_space, is_tail, is_quote, is_nul, is_other;
	logic cont, close_str, fin, idle_path, consume, start_tok, idle_emit, ended;
	logic [OFFSET_BITS-1:0] off_inc;
	kwl_pkg::len_t          len_inc;
	kwl_pkg::kind_t         kind_a, kind_b;
	logic [RES_W-2:0]       tok_a, tok_b;

	assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	assign is_digit  = (c >= "0" && c <= "9");
	assign is_space  = (c == kwl_pkg::CH_SPACE)
		|| (c >= kwl_pkg::CH_TAB && c <= kwl_pkg::CH_CR);
	assign is_tail   = is_letter || is_digit || c == kwl_pkg::CH_DOT
		|| c == kwl_pkg::CH_UNDER;
	assign is_quote  = (c == kwl_pkg::CH_QUOTE);
	assign is_nul    = (c == kwl_pkg::CH_NUL);
	assign is_other  = ~is_nul & ~is_space & ~is_letter & ~is_digit & ~is_quote;

	assign ended     = (mode_q == kwl_pkg::MODE_ENDED);
	assign cont      = (mode_q == kwl_pkg::MODE_IDENT && is_tail)
		|| (mode_q == kwl_pkg::MODE_NUMBER && is_digit)
		|| (mode_q == kwl_pkg::MODE_STRING && !is_quote && !is_nul);
	assign close_str = (mode_q == kwl_pkg::MODE_STRING) && is_quote;
	assign fin       = (mode_q == kwl_pkg::MODE_IDENT && !is_tail)
		|| (mode_q == kwl_pkg::MODE_NUMBER && !is_digit)
		|| (mode_q == kwl_pkg::MODE_STRING && is_nul);
	assign idle_path = (mode_q == kwl_pkg::MODE_IDLE) || fin;
	assign consume   = cont || close_str || (idle_path && !is_nul);
	assign start_tok = idle_path && (is_letter || is_digit || is_quote);
	assign idle_emit = idle_path && (is_nul || is_other);

	assign off_inc = (off_q != '1) ? off_q + 1'b1 : off_q;
	assign len_inc = (len_q != '1) ? len_q + 1'b1 : len_q;

	// next state
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			kwl_pkg::MODE_ENDED: mode_d = kwl_pkg::MODE_ENDED;
			default: begin
				if (close_str) begin
					mode_d = kwl_pkg::MODE_IDLE;
				end else if (idle_path) begin
					if (is_nul)
						mode_d = kwl_pkg::MODE_ENDED;
					else if (is_letter)
						mode_d = kwl_pkg::MODE_IDENT;
					else if (is_digit)
						mode_d = kwl_pkg::MODE_NUMBER;
					else if (is_quote)
						mode_d = kwl_pkg::MODE_STRING;
					else
						mode_d = kwl_pkg::MODE_IDLE;
				end
			end
		endcase
	end

	// counters and token bookkeeping
	always_comb begin
		line_d    = line_q;
		col_d     = col_q;
		off_d     = off_q;
		beg_col_d = beg_col_q;
		beg_off_d = beg_off_q;
		len_d     = len_q;
		cand_d    = cand_q;
		if (consume) begin
			off_d = off_inc;
			if (c == kwl_pkg::CH_NL) begin
				line_d = (line_q != '1) ? line_q + 1'b1 : line_q;
				col_d  = COLUMN_BITS'(1);
			end else begin
				col_d = (col_q != '1) ? col_q + 1'b1 : col_q;
			end
		end
		if (cont) begin
			len_d = len_inc;
			if (mode_q == kwl_pkg::MODE_IDENT)
				cand_d = kwl_pkg::kw_narrow(cand_q, len_q, c);
		end
		if (start_tok) begin
			beg_col_d = col_q;
			beg_off_d = is_quote ? off_inc : off_q;
			len_d     = is_quote ? kwl_pkg::len_t'(0) : kwl_pkg::len_t'(1);
			cand_d    = is_letter ? kwl_pkg::kw_narrow(kwl_pkg::KW_ALL, '0, c)
				: kwl_pkg::KW_ALL;
		end
	end

	// result beats
	always_comb begin
		case (mode_q)
			kwl_pkg::MODE_IDENT:  kind_a = kwl_pkg::kw_kind(cand_q, len_q);
			kwl_pkg::MODE_NUMBER: kind_a = kwl_pkg::KIND_NUMBER;
			default:              kind_a = kwl_pkg::KIND_STRING;
		endcase
		kind_b = (ended || is_nul) ? kwl_pkg::KIND_END : kwl_pkg::KIND_UNKNOWN;
		tok_a  = {kind_a, line_q, beg_col_q, beg_off_q, len_q, kwl_pkg::CH_NUL};
		if (kind_b == kwl_pkg::KIND_END)
			tok_b = {kind_b, line_q, col_q, off_q, kwl_pkg::len_t'(0), kwl_pkg::CH_NUL};
		else
			tok_b = {kind_b, line_q, col_q, off_q, kwl_pkg::len_t'(1), c};

		push_cnt = 2'd0;
		res0     = {tok_b, 1'b1};
		res1     = {tok_b, 1'b1};
		if (step) begin
			if (ended) begin
				push_cnt = 2'd1;
			end else if (close_str || fin) begin
				if (fin && idle_emit) begin
					push_cnt = 2'd2;
					res0     = {tok_a, 1'b0};
				end else begin
					push_cnt = 2'd1;
					res0     = {tok_a, 1'b1};
				end
			end else if (idle_emit) begin
				push_cnt = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= kwl_pkg::MODE_IDLE;
			line_q    <= LINE_BITS'(1);
			col_q     <= COLUMN_BITS'(1);
			off_q     <= '0;
			beg_col_q <= COLUMN_BITS'(1);
			beg_off_q <= '0;
			len_q     <= '0;
			cand_q    <= kwl_pkg::KW_ALL;
		end else if (step) begin
			mode_q    <= mode_d;
			line_q    <= line_d;
			col_q     <= col_d;
			off_q     <= off_d;
			beg_col_q <= beg_col_d;
			beg_off_q <= beg_off_d;
			len_q     <= len_d;
			cand_q    <= cand_d;
		end
	end

endmodule

[design/keyword_lexer_stream.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_lexer_stream
// Streaming tokenizer with position tracking and keyword recognition.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle. A byte enters an input register, is scanned
// once the result queue has room, and its tokens land in a four-entry result
// queue, from which they are offered in order. Most bytes make zero or one
// token; a byte that closes a token and is itself an unknown byte or the end
// marker makes two beats, so a stream is sustained at one byte per cycle as
// long as the output port, which moves one beat per cycle, keeps up. Input
// stalls only while the queue holds more than two beats. No start-up sweep.
// ----------------------------------------------------------------------------
module keyword_lexer_stream #(
	parameter int LINE_BITS   = kwl_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = kwl_pkg::COLUMN_BITS_DEF,
	parameter int OFFSET_BITS = kwl_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  logic [7:0]             char_code,
	output logic                   token_valid,
	input  logic                   token_stall,
	output logic [4:0]             token_kind,
	output logic [LINE_BITS-1:0]   token_line,
	output logic [COLUMN_BITS-1:0] start_column,
	output logic [OFFSET_BITS-1:0] start_offset,
	output logic [15:0]            token_length,
	output logic [7:0]             unknown_byte,
	output logic                   last_of_run
);

	localparam int LEN_W  = kwl_pkg::LEN_BITS;
	localparam int CHR_W  = kwl_pkg::CHAR_BITS;
	localparam int KND_W  = kwl_pkg::KIND_BITS;
	localparam int RES_W  = KND_W + LINE_BITS + COLUMN_BITS + OFFSET_BITS + LEN_W + CHR_W + 1;
	localparam int UB_LO  = 1;
	localparam int LEN_LO = UB_LO + CHR_W;
	localparam int OFF_LO = LEN_LO + LEN_W;
	localparam int COL_LO = OFF_LO + OFFSET_BITS;
	localparam int LIN_LO = COL_LO + COLUMN_BITS;
	localparam int KND_LO = LIN_LO + LINE_BITS;

	logic               valid_s1;
	kwl_pkg::char_t     char_s1;
	logic               room;
	logic               step;
	logic               accept;
	kwl_pkg::push_cnt_t push_cnt;
	logic [RES_W-1:0]   res0, res1, head;

	assign byte_stall = valid_s1 & ~room;
	assign accept     = byte_valid & ~byte_stall;
	assign step       = valid_s1 & room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			char_s1 <= char_code;
	end

	kwl_scanner #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS),
		.OFFSET_BITS (OFFSET_BITS),
		.RES_W       (RES_W)
	) u_scanner (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.c        (char_s1),
		.push_cnt (push_cnt),
		.res0     (res0),
		.res1     (res1)
	);

	kwl_res_queue #(
		.WIDTH (RES_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push_d0  (res0),
		.push_d1  (res1),
		.room     (room),
		.rd_valid (token_valid),
		.rd_stall (token_stall),
		.rd_data  (head)
	);

	assign token_kind   = head[KND_LO +: KND_W];
	assign token_line   = head[LIN_LO +: LINE_BITS];
	assign start_column = head[COL_LO +: COLUMN_BITS];
	assign start_offset = head[OFF_LO +: OFFSET_BITS];
	assign token_length = head[LEN_LO +: LEN_W];
	assign unknown_byte = head[UB_LO +: CHR_W];
	assign last_of_run  = head[0];

endmodule

[bench/keyword_lexer_stream_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_lexer_stream_test
// Self-checking bench for the streaming keyword lexer. A queue of source bytes
// (directed cases, random token streams, then an unterminated string and the
// end marker) is driven byte by byte. A behavioral tokenizer in the bench
// predicts each beat, and results are compared in order. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module keyword_lexer_stream_test;

	localparam int LW = kwl_pkg::LINE_BITS_DEF;
	localparam int CW = kwl_pkg::COLUMN_BITS_DEF;
	localparam int OW = kwl_pkg::OFFSET_BITS_DEF;
	localparam int DRAIN_MARK = -1;
	localparam int CALM_MARK  = -2;
	localparam int HOLD_CYCLES = 40;

	typedef struct packed {
		kwl_pkg::kind_t kind;
		logic [LW-1:0]  line;
		logic [CW-1:0]  col;
		logic [OW-1:0]  off;
		kwl_pkg::len_t  len;
		kwl_pkg::char_t ubyte;
		logic           last;
	} token_exp_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          byte_valid = 1'b0;
	logic          byte_stall;
	logic [7:0]    char_code = 8'h00;
	logic          token_valid;
	logic          token_stall = 1'b0;
	logic [4:0]    token_kind;
	logic [LW-1:0] token_line;
	logic [CW-1:0] start_column;
	logic [OW-1:0] start_offset;
	logic [15:0]   token_length;
	logic [7:0]    unknown_byte;
	logic          last_of_run;

	keyword_lexer_stream u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.char_code   (char_code),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_kind  (token_kind),
		.token_line  (token_line),
		.start_column(start_column),
		.start_offset(start_offset),
		.token_length(token_length),
		.unknown_byte(unknown_byte),
		.last_of_run (last_of_run)
	);

	always #2 clk = ~clk;

	string kw_words [kwl_pkg::KW_COUNT] = '{
		"func", "start", "end", "call",
		"safe.add", "safe.sub", "safe.mul", "safe.div",
		"tuple.pack", "tuple.unpack", "list.append", "list.remove",
		"language.parallel", "language.sync"
	};
	string tail_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._";

	// tokenizer state
	kwl_pkg::mode_t    lex_mode = kwl_pkg::MODE_IDLE;
	logic [LW-1:0]     cur_line = LW'(1);
	logic [CW-1:0]     cur_col = CW'(1);
	logic [OW-1:0]     cur_off = '0;
	logic [CW-1:0]     tok_col = CW'(1);
	logic [OW-1:0]     tok_off = '0;
	kwl_pkg::len_t     tok_len = '0;
	kwl_pkg::kw_mask_t kw_live = kwl_pkg::KW_ALL;

	token_exp_t pending_tokens[$];
	token_exp_t byte_tokens[$];
	int         source_bytes[$];

	int  err_count = 0;
	int  tokens_seen = 0;
	bit  calm = 1'b0;
	bit  src_done = 1'b0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	function automatic bit is_alpha(kwl_pkg::char_t c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_num(kwl_pkg::char_t c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_blank(kwl_pkg::char_t c);
		return c == kwl_pkg::CH_SPACE || (c >= kwl_pkg::CH_TAB && c <= kwl_pkg::CH_CR);
	endfunction

	function automatic bit is_tail(kwl_pkg::char_t c);
		return is_alpha(c) || is_num(c) || c == kwl_pkg::CH_DOT || c == kwl_pkg::CH_UNDER;
	endfunction

	function automatic void advance(kwl_pkg::char_t c);
		if (cur_off != '1) cur_off++;
		if (c == kwl_pkg::CH_NL) begin
			if (cur_line != '1) cur_line++;
			cur_col = CW'(1);
		end else if (cur_col != '1) begin
			cur_col++;
		end
	endfunction

	function automatic void grow_text();
		if (tok_len != '1) tok_len++;
	endfunction

	function automatic void narrow(kwl_pkg::char_t c);
		for (int i = 0; i < kwl_pkg::KW_COUNT; i++) begin
			if (int'(tok_len) >= kw_words[i].len() || kw_words[i][int'(tok_len)] != c)
				kw_live[i] = 1'b0;
		end
	endfunction

	function automatic kwl_pkg::kind_t classify();
		for (int i = 0; i < kwl_pkg::KW_COUNT; i++) begin
			if (kw_live[i] && int'(tok_len) == kw_words[i].len())
				return kwl_pkg::KIND_KW0 + kwl_pkg::kind_t'(i);
		end
		return kwl_pkg::KIND_IDENT;
	endfunction

	function automatic void emit(kwl_pkg::kind_t k, logic [CW-1:0] col, logic [OW-1:0] off,
			kwl_pkg::len_t len, kwl_pkg::char_t ub);
		byte_tokens.push_back('{k, cur_line, col, off, len, ub, 1'b0});
	endfunction

	function automatic void start_token();
		tok_col = cur_col;
		tok_off = cur_off;
		tok_len = '0;
		kw_live = kwl_pkg::KW_ALL;
	endfunction

	// tokens caused by one source byte, appended to pending_tokens
	function automatic void lex_byte(kwl_pkg::char_t c);
		bit swallowed;
		swallowed = 1'b0;
		byte_tokens.delete();
		case (lex_mode)
			kwl_pkg::MODE_ENDED: begin
				emit(kwl_pkg::KIND_END, cur_col, cur_off, '0, '0);
				swallowed = 1'b1;
			end
			kwl_pkg::MODE_IDENT: begin
				if (is_tail(c)) begin
					narrow(c);
					grow_text();
					advance(c);
					swallowed = 1'b1;
				end else begin
					emit(classify(), tok_col, tok_off, tok_len, '0);
					lex_mode = kwl_pkg::MODE_IDLE;
				end
			end
			kwl_pkg::MODE_NUMBER: begin
				if (is_num(c)) begin
					grow_text();
					advance(c);
					swallowed = 1'b1;
				end else begin
					emit(kwl_pkg::KIND_NUMBER, tok_col, tok_off, tok_len, '0);
					lex_mode = kwl_pkg::MODE_IDLE;
				end
			end
			kwl_pkg::MODE_STRING: begin
				if (c == kwl_pkg::CH_QUOTE) begin
					advance(c);
					emit(kwl_pkg::KIND_STRING, tok_col, tok_off, tok_len, '0);
					lex_mode = kwl_pkg::MODE_IDLE;
					swallowed = 1'b1;
				end else if (c != kwl_pkg::CH_NUL) begin
					grow_text();
					advance(c);
					swallowed = 1'b1;
				end else begin
					emit(kwl_pkg::KIND_STRING, tok_col, tok_off, tok_len, '0);
					lex_mode = kwl_pkg::MODE_IDLE;
				end
			end
			default: ;
		endcase
		if (!swallowed) begin
			if (c == kwl_pkg::CH_NUL) begin
				emit(kwl_pkg::KIND_END, cur_col, cur_off, '0, '0);
				lex_mode = kwl_pkg::MODE_ENDED;
			end else if (is_blank(c)) begin
				advance(c);
			end else if (is_alpha(c)) begin
				start_token();
				narrow(c);
				tok_len = kwl_pkg::len_t'(1);
				advance(c);
				lex_mode = kwl_pkg::MODE_IDENT;
			end else if (is_num(c)) begin
				start_token();
				tok_len = kwl_pkg::len_t'(1);
				advance(c);
				lex_mode = kwl_pkg::MODE_NUMBER;
			end else if (c == kwl_pkg::CH_QUOTE) begin
				start_token();
				advance(c);
				tok_off = cur_off;
				lex_mode = kwl_pkg::MODE_STRING;
			end else begin
				emit(kwl_pkg::KIND_UNKNOWN, cur_col, cur_off, kwl_pkg::len_t'(1), c);
				advance(c);
			end
		end
		if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size() - 1].last = 1'b1;
		foreach (byte_tokens[i]) pending_tokens.push_back(byte_tokens[i]);
	endfunction

	function automatic kwl_pkg::char_t pick_tail();
		return tail_set[$urandom_range(0, tail_set.len() - 1)];
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) source_bytes.push_back(s[i]);
	endfunction

	task automatic add_random_token();
		int             pick;
		int             n;
		string          w;
		kwl_pkg::char_t c;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			// keyword, sometimes cut short, capitalized or extended
			w = kw_words[$urandom_range(0, kwl_pkg::KW_COUNT - 1)];
			n = $urandom_range(0, 5);
			if (n == 0) w = w.substr(0, $urandom_range(0, w.len() - 2));
			else if (n == 1) w.putc(0, w[0] - 8'h20);
			push_text(w);
			if (n == 2) source_bytes.push_back(pick_tail());
		end else if (pick < 45) begin
			c = $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
			source_bytes.push_back(c);
			n = $urandom_range(0, 7);
			repeat (n) source_bytes.push_back(pick_tail());
		end else if (pick < 60) begin
			n = $urandom_range(1, 6);
			repeat (n) source_bytes.push_back($urandom_range(48, 57));
		end else if (pick < 72) begin
			source_bytes.push_back(kwl_pkg::CH_QUOTE);
			n = $urandom_range(0, 6);
			repeat (n) begin
				do c = 8'($urandom_range(1, 255)); while (c == kwl_pkg::CH_QUOTE);
				source_bytes.push_back(c);
			end
			source_bytes.push_back(kwl_pkg::CH_QUOTE);
		end else if (pick < 88) begin
			do c = 8'($urandom_range(1, 255));
			while (is_alpha(c) || is_num(c) || is_blank(c) || c == kwl_pkg::CH_QUOTE);
			source_bytes.push_back(c);
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) source_bytes.push_back($urandom_range(1, 255));
		end
		n = $urandom_range(0, 9);
		if (n < 5) source_bytes.push_back(kwl_pkg::CH_SPACE);
		else if (n == 5) source_bytes.push_back(kwl_pkg::CH_NL);
		else if (n == 6) source_bytes.push_back($urandom_range(9, 13));
	endtask

	// source side
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall) lex_byte(char_code);
			if (!byte_valid || !byte_stall) begin
				while (source_bytes.size() > 0 && source_bytes[0] == CALM_MARK) begin
					void'(source_bytes.pop_front());
					calm = 1'b1;
				end
				if (tx_gap > 0) begin
					tx_gap--;
					byte_valid <= 1'b0;
				end else if (source_bytes.size() == 0) begin
					byte_valid <= 1'b0;
					src_done = 1'b1;
				end else if (source_bytes[0] == DRAIN_MARK) begin
					byte_valid <= 1'b0;
					if (pending_tokens.size() == 0) void'(source_bytes.pop_front());
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					tx_gap = $urandom_range(0, 3);
					byte_valid <= 1'b0;
				end else begin
					byte_valid <= 1'b1;
					char_code <= 8'(source_bytes.pop_front());
				end
			end
		end
	end

	// sink stall, with one long hold once results are flowing
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				token_stall <= 1'b1;
			end else if (!hold_done && tokens_seen >= 60) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				token_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				token_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(0, 3);
				token_stall <= 1'b1;
			end else begin
				token_stall <= 1'b0;
			end
		end
	end

	// result check
	always @(posedge clk) begin
		token_exp_t e;
		if (arst_n && token_valid && !token_stall) begin
			tokens_seen++;
			if (pending_tokens.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected beat: kind %0d line %0d col %0d off %0d len %0d",
						token_kind, token_line, start_column, start_offset, token_length);
			end else begin
				e = pending_tokens.pop_front();
				if (token_kind !== e.kind || token_line !== e.line || start_column !== e.col
						|| start_offset !== e.off || token_length !== e.len
						|| unknown_byte !== e.ubyte || last_of_run !== e.last) begin
					err_count++;
					if (err_count <= 10) begin
						$display("beat %0d exp: kind %0d line %0d col %0d off %0d len %0d byte %02h last %0d",
							tokens_seen, e.kind, e.line, e.col, e.off, e.len, e.ubyte, e.last);
						$display("beat %0d got: kind %0d line %0d col %0d off %0d len %0d byte %02h last %0d",
							tokens_seen, token_kind, token_line, start_column, start_offset,
							token_length, unknown_byte, last_of_run);
					end
				end
			end
		end
	end

	initial begin
		// directed: keyword, number cut by unknown, one-char string, ident cut by
		// high byte, every blank, ident with dot and underscore cut by 0x80,
		// empty string
		push_text("end 9,\"q\"z");
		source_bytes.push_back(8'hFF);
		push_text("\n\v\f\r\tA_.0");
		source_bytes.push_back(8'h80);
		source_bytes.push_back(8'h01);
		push_text("\"\"7a\n");

		while (source_bytes.size() < 230) add_random_token();
		source_bytes.push_back(DRAIN_MARK);
		while (source_bytes.size() < 390) add_random_token();
		source_bytes.push_back(CALM_MARK);
		repeat (15) add_random_token();

		// unterminated string closed by the end marker, then bytes after the end
		push_text("\"ab");
		source_bytes.push_back(kwl_pkg::CH_NUL);
		source_bytes.push_back(kwl_pkg::CH_NUL);
		source_bytes.push_back(8'hFF);
		source_bytes.push_back($urandom_range(1, 254));
		source_bytes.push_back("a");

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!src_done) @(posedge clk);
		while (pending_tokens.size() > 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
